>>> hw/rtl/trc_pkg.sv
// Package for the trace capture trigger: types, codes and reset constants.
// Has no dependencies. All other files but trc_rem refer to it by scoped names.
package trc_pkg;

    typedef enum logic [1:0] {
        ACT_SAMPLE  = 2'd0,
        ACT_START   = 2'd1,
        ACT_STOP    = 2'd2,
        ACT_RELEASE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EXEC
    } t_bstate;

    typedef enum logic [2:0] {
        CFG_LOW      = 3'd0,
        CFG_HIGH     = 3'd1,
        CFG_FULL     = 3'd2,
        CFG_ARMED    = 3'd3,
        CFG_FAULT    = 3'd4,
        CFG_DISARMED = 3'd5
    } t_cfg_idx;

    localparam logic [2:0] LVL_EVENTS = 3'd1;
    localparam logic [2:0] LVL_LOW    = 3'd2;
    localparam logic [2:0] LVL_HIGH   = 3'd3;
    localparam logic [2:0] LVL_FULL   = 3'd4;

    localparam int EV_STARTED  = 0;
    localparam int EV_STATE    = 1;
    localparam int EV_FAILSAFE = 2;
    localparam int EV_RATE     = 3;
    localparam int EV_CONTROL  = 4;
    localparam int EV_SAT      = 5;

    localparam logic [19:0] RST_LOW      = 20'd100000;
    localparam logic [19:0] RST_HIGH     = 20'd10000;
    localparam logic [19:0] RST_FULL     = 20'd1000;
    localparam logic [7:0]  RST_ARMED    = 8'd2;
    localparam logic [7:0]  RST_FAULT    = 8'd3;
    localparam logic [7:0]  RST_DISARMED = 8'd1;

    typedef struct packed {
        t_action     action;
        logic [2:0]  level;
        logic        level_ok;
        logic [63:0] now_us;
        logic [7:0]  sys;
        logic [7:0]  fs;
        logic [7:0]  rr;
        logic [7:0]  cr;
        logic        sat_now;
        logic [6:0]  rel;
    } t_item;

    typedef struct packed {
        logic [19:0] low;
        logic [19:0] high;
        logic [19:0] full;
        logic [7:0]  armed;
        logic [7:0]  fault;
        logic [7:0]  disarmed;
    } t_cfg;

endpackage

>>> hw/rtl/trc_front.sv
// Front part: accepts transactions, classifies them and holds them in a
// two-entry queue for the back part. Depends on trc_pkg.
module trc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  logic [2:0]           i_level,
    input  logic [63:0]          i_now_us,
    input  logic [7:0]           i_system_state,
    input  logic [7:0]           i_failsafe_state,
    input  logic [7:0]           i_rate_result,
    input  logic [7:0]           i_control_result,
    input  logic                 i_mixer_valid,
    input  logic                 i_mixer_saturated,
    input  logic [6:0]           i_release_count,
    output logic                 o_q_valid,
    output trc_pkg::t_item       o_q_item,
    input  logic                 i_q_pop
);

    trc_pkg::t_item r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    trc_pkg::t_item w_item;
    logic           w_push;

    always_comb begin
        w_item.action   = trc_pkg::t_action'(i_action);
        w_item.level    = i_level;
        w_item.level_ok = (i_level >= trc_pkg::LVL_EVENTS) && (i_level <= trc_pkg::LVL_FULL);
        w_item.now_us   = i_now_us;
        w_item.sys      = i_system_state;
        w_item.fs       = i_failsafe_state;
        w_item.rr       = i_rate_result;
        w_item.cr       = i_control_result;
        w_item.sat_now  = i_mixer_valid & i_mixer_saturated;
        w_item.rel      = i_release_count;
    end

    assign o_stall   = (r_cnt == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

    q_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    q_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    q_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_q_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count missed a push");

endmodule

>>> hw/rtl/trc_rem.sv
// Remainder unit: restoring division of a 64-bit value by a 20-bit divisor,
// one quotient bit a cycle, remainder only. Depends on nothing.
module trc_rem (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [19:0] i_divisor,
    output logic        o_busy,
    output logic [19:0] o_rem
);

    logic [63:0] r_dvd;
    logic [19:0] r_rem;
    logic [6:0]  r_cnt;
    logic [20:0] w_sh;
    logic [20:0] w_dif;

    assign w_sh   = {r_rem, r_dvd[63]};
    assign w_dif  = w_sh - {1'b0, i_divisor};
    assign o_busy = (r_cnt != 7'd0);
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (o_busy) begin
            r_dvd <= {r_dvd[62:0], 1'b0};
            r_rem <= (w_sh >= {1'b0, i_divisor}) ? w_dif[19:0] : w_sh[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 7'd0;
        end else if (i_start) begin
            r_cnt <= 7'd64;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 7'd1;
        end
    end

    rem_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !o_busy) else $error("remainder unit restarted while busy");
    rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_busy && i_divisor != 20'd0) |=> (r_rem < i_divisor))
        else $error("remainder not below divisor");
    rem_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_cnt == 7'd64)) else $error("remainder count not loaded");

endmodule

>>> hw/rtl/trc_back.sv
// Back part: capture state, due-time catch-up through trc_rem, ring counts
// and the output register. Depends on trc_pkg and trc_rem.
module trc_back #(
    parameter int RING_SLOTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  trc_pkg::t_cfg        i_cfg,
    input  logic                 i_q_valid,
    input  trc_pkg::t_item       i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_accepted,
    output logic [5:0]           o_slot_index,
    output logic [63:0]          o_record_sequence,
    output logic [5:0]           o_event_flags,
    output logic [31:0]          o_capture_number,
    output logic [2:0]           o_current_level,
    output logic [6:0]           o_pending_records,
    output logic [63:0]          o_dropped_records,
    output logic                 o_capturing
);

    localparam int SW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam logic [SW-1:0] SLOT_LAST = SW'(RING_SLOTS - 1);

    trc_pkg::t_bstate r_state, n_state;
    trc_pkg::t_item   r_item;
    logic             r_due;

    logic [2:0]  r_level, n_level;
    logic [31:0] r_capt, n_capt;
    logic [19:0] r_iv, n_iv;
    logic [63:0] r_next, n_next;
    logic        r_seen, n_seen;
    logic [7:0]  r_lsys, n_lsys, r_lfs, n_lfs, r_lrr, n_lrr, r_lcr, n_lcr;
    logic        r_lsat, n_lsat;
    logic        r_armed, n_armed;
    logic [63:0] r_wr, n_wr, r_rel, n_rel, r_drop, n_drop;
    logic [SW-1:0] r_slot, n_slot;

    logic        r_ov;
    logic        r_o_acc, n_o_acc;
    logic [5:0]  r_o_slot, n_o_slot, r_o_ev, n_o_ev;
    logic [63:0] r_o_seq, n_o_seq;
    logic [6:0]  r_o_pend, n_o_pend;

    logic        w_out_free, w_fire, w_due_now, w_rem_busy;
    logic [19:0] w_rem;
    logic [63:0] w_pend_old, w_pend_new, w_base, w_used;
    logic [64:0] w_sum;

    assign w_out_free = !r_ov || !i_stall;
    assign o_q_pop    = (r_state == trc_pkg::S_IDLE) && i_q_valid;
    assign w_fire     = (r_state == trc_pkg::S_EXEC) && w_out_free;
    assign w_due_now  = (i_q_item.action == trc_pkg::ACT_SAMPLE) && (r_level != 3'd0)
                        && (r_iv != 20'd0) && (i_q_item.now_us >= r_next);

    trc_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (o_q_pop && w_due_now),
        .i_dividend (i_q_item.now_us - r_next),
        .i_divisor  (r_iv),
        .o_busy     (w_rem_busy),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            trc_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    n_state = w_due_now ? trc_pkg::S_DIV : trc_pkg::S_EXEC;
                end
            end
            trc_pkg::S_DIV: begin
                if (!w_rem_busy) begin
                    n_state = trc_pkg::S_EXEC;
                end
            end
            trc_pkg::S_EXEC: begin
                if (w_out_free) begin
                    n_state = trc_pkg::S_IDLE;
                end
            end
            default: n_state = trc_pkg::S_IDLE;
        endcase
    end

    assign w_pend_old = (r_wr < r_rel) ? 64'd0 : (r_wr - r_rel);
    assign w_used     = r_wr - r_rel;
    assign w_base     = r_item.now_us - {44'd0, w_rem};
    assign w_sum      = {1'b0, w_base} + {45'd0, r_iv};

    always_comb begin
        logic stop_after;
        n_level  = r_level;
        n_capt   = r_capt;
        n_iv     = r_iv;
        n_next   = r_next;
        n_seen   = r_seen;
        n_lsys   = r_lsys;
        n_lfs    = r_lfs;
        n_lrr    = r_lrr;
        n_lcr    = r_lcr;
        n_lsat   = r_lsat;
        n_armed  = r_armed;
        n_wr     = r_wr;
        n_rel    = r_rel;
        n_drop   = r_drop;
        n_slot   = r_slot;
        n_o_acc  = 1'b0;
        n_o_slot = 6'd0;
        n_o_seq  = 64'd0;
        n_o_ev   = 6'd0;
        stop_after = 1'b0;
        if (w_fire) begin
            case (r_item.action)
                trc_pkg::ACT_START: begin
                    if (r_level == 3'd0 && r_item.level_ok) begin
                        n_level = r_item.level;
                        n_capt  = (r_capt != '1) ? r_capt + 32'd1 : r_capt;
                        case (r_item.level)
                            trc_pkg::LVL_LOW:  n_iv = i_cfg.low;
                            trc_pkg::LVL_HIGH: n_iv = i_cfg.high;
                            trc_pkg::LVL_FULL: n_iv = i_cfg.full;
                            default:           n_iv = 20'd0;
                        endcase
                        n_next  = r_item.now_us;
                        n_seen  = 1'b0;
                        n_lsys  = 8'd0;
                        n_lfs   = 8'd0;
                        n_lrr   = 8'd0;
                        n_lcr   = 8'd0;
                        n_lsat  = 1'b0;
                        n_armed = 1'b0;
                        n_wr    = 64'd0;
                        n_rel   = 64'd0;
                        n_drop  = 64'd0;
                        n_slot  = '0;
                        n_o_acc = 1'b1;
                    end
                end
                trc_pkg::ACT_STOP: begin
                    n_level = 3'd0;
                    n_iv    = 20'd0;
                    n_o_acc = 1'b1;
                end
                trc_pkg::ACT_RELEASE: begin
                    if ({57'd0, r_item.rel} <= w_pend_old) begin
                        n_rel   = r_rel + {57'd0, r_item.rel};
                        n_o_acc = 1'b1;
                    end
                end
                trc_pkg::ACT_SAMPLE: begin
                    if (r_level != 3'd0) begin
                        if (!r_seen) begin
                            n_o_ev[trc_pkg::EV_STARTED] = 1'b1;
                        end else begin
                            n_o_ev[trc_pkg::EV_STATE]    = (r_item.sys != r_lsys);
                            n_o_ev[trc_pkg::EV_FAILSAFE] = (r_item.fs != r_lfs);
                            n_o_ev[trc_pkg::EV_RATE]     = (r_item.rr != r_lrr);
                            n_o_ev[trc_pkg::EV_CONTROL]  = (r_item.cr != r_lcr);
                            n_o_ev[trc_pkg::EV_SAT]      = r_item.sat_now && !r_lsat;
                        end
                        n_lsys  = r_item.sys;
                        n_lfs   = r_item.fs;
                        n_lrr   = r_item.rr;
                        n_lcr   = r_item.cr;
                        n_lsat  = r_item.sat_now;
                        n_seen  = 1'b1;
                        n_armed = r_armed || (r_item.sys == i_cfg.armed);
                        if (r_due) begin
                            n_next = w_sum[64] ? '1 : w_sum[63:0];
                        end
                        stop_after = (r_item.sys == i_cfg.fault)
                                     || (n_armed && r_item.sys == i_cfg.disarmed);
                        if (r_due || n_o_ev != 6'd0 || stop_after) begin
                            if (w_used >= 64'(RING_SLOTS)) begin
                                n_drop = (r_drop != '1) ? r_drop + 64'd1 : r_drop;
                            end else begin
                                n_o_slot = 6'(r_slot);
                                n_o_seq  = r_wr + 64'd1;
                                n_wr     = r_wr + 64'd1;
                                n_slot   = (r_slot == SLOT_LAST) ? '0 : r_slot + SW'(1);
                                n_o_acc  = 1'b1;
                            end
                            if (stop_after) begin
                                n_level = 3'd0;
                                n_iv    = 20'd0;
                            end
                        end
                    end
                end
                default: n_o_acc = 1'b0;
            endcase
        end
        w_pend_new = (n_wr < n_rel) ? 64'd0 : (n_wr - n_rel);
        n_o_pend   = (w_pend_new > 64'd127) ? 7'd127 : w_pend_new[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
            r_due  <= w_due_now;
        end
        if (w_fire) begin
            r_o_acc  <= n_o_acc;
            r_o_slot <= n_o_slot;
            r_o_seq  <= n_o_seq;
            r_o_ev   <= n_o_ev;
            r_o_pend <= n_o_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trc_pkg::S_IDLE;
            r_ov    <= 1'b0;
            r_level <= 3'd0;
            r_capt  <= 32'd0;
            r_iv    <= 20'd0;
            r_next  <= 64'd0;
            r_seen  <= 1'b0;
            r_lsys  <= 8'd0;
            r_lfs   <= 8'd0;
            r_lrr   <= 8'd0;
            r_lcr   <= 8'd0;
            r_lsat  <= 1'b0;
            r_armed <= 1'b0;
            r_wr    <= 64'd0;
            r_rel   <= 64'd0;
            r_drop  <= 64'd0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            r_level <= n_level;
            r_capt  <= n_capt;
            r_iv    <= n_iv;
            r_next  <= n_next;
            r_seen  <= n_seen;
            r_lsys  <= n_lsys;
            r_lfs   <= n_lfs;
            r_lrr   <= n_lrr;
            r_lcr   <= n_lcr;
            r_lsat  <= n_lsat;
            r_armed <= n_armed;
            r_wr    <= n_wr;
            r_rel   <= n_rel;
            r_drop  <= n_drop;
            r_slot  <= n_slot;
        end
    end

    assign o_valid           = r_ov;
    assign o_accepted        = r_o_acc;
    assign o_slot_index      = r_o_slot;
    assign o_record_sequence = r_o_seq;
    assign o_event_flags     = r_o_ev;
    assign o_capture_number  = r_capt;
    assign o_current_level   = r_level;
    assign o_pending_records = r_o_pend;
    assign o_dropped_records = r_drop;
    assign o_capturing       = (r_level != 3'd0);

    bk_div_capturing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == trc_pkg::S_DIV) |-> (r_level != 3'd0 && r_iv != 20'd0))
        else $error("catch-up running with capture off");
    bk_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= 64'(RING_SLOTS)) else $error("ring holds more than its slots");
    bk_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= trc_pkg::LVL_FULL) else $error("capture level out of range");
    bk_one_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != trc_pkg::S_IDLE)) else $error("popped item not worked");

endmodule

>>> hw/rtl/trace_capture_trigger_ring.sv
// Top level of the trace capture trigger: configuration registers, front
// queue and back part. Depends on trc_pkg, trc_front and trc_back.
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_stall   | action, level, now_us, codes, release
//   out     | output    | o_out_valid / i_out_stall | accepted ... capturing
//   cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_wdata
//
// The back part pops an item only in its idle state. A sample that is due for a periodic
// record first runs the due-time catch-up, a 64-step remainder, one bit a cycle; each item
// is then worked into the output register. A two-entry queue takes input while the back
// part works; a stalled output holds the back part. Reset is synchronous.
module trace_capture_trigger_ring #(
    parameter int RING_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [2:0]  i_level,
    input  logic [63:0] i_now_us,
    input  logic [7:0]  i_system_state,
    input  logic [7:0]  i_failsafe_state,
    input  logic [7:0]  i_rate_result,
    input  logic [7:0]  i_control_result,
    input  logic        i_mixer_valid,
    input  logic        i_mixer_saturated,
    input  logic [6:0]  i_release_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output logic [5:0]  o_slot_index,
    output logic [63:0] o_record_sequence,
    output logic [5:0]  o_event_flags,
    output logic [31:0] o_capture_number,
    output logic [2:0]  o_current_level,
    output logic [6:0]  o_pending_records,
    output logic [63:0] o_dropped_records,
    output logic        o_capturing,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_wdata
);

    trc_pkg::t_cfg  r_cfg;
    logic           w_q_valid, w_q_pop;
    trc_pkg::t_item w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low      <= trc_pkg::RST_LOW;
            r_cfg.high     <= trc_pkg::RST_HIGH;
            r_cfg.full     <= trc_pkg::RST_FULL;
            r_cfg.armed    <= trc_pkg::RST_ARMED;
            r_cfg.fault    <= trc_pkg::RST_FAULT;
            r_cfg.disarmed <= trc_pkg::RST_DISARMED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                trc_pkg::CFG_LOW:      r_cfg.low      <= i_cfg_wdata;
                trc_pkg::CFG_HIGH:     r_cfg.high     <= i_cfg_wdata;
                trc_pkg::CFG_FULL:     r_cfg.full     <= i_cfg_wdata;
                trc_pkg::CFG_ARMED:    r_cfg.armed    <= i_cfg_wdata[7:0];
                trc_pkg::CFG_FAULT:    r_cfg.fault    <= i_cfg_wdata[7:0];
                trc_pkg::CFG_DISARMED: r_cfg.disarmed <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    trc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_in_valid),
        .o_stall           (o_in_stall),
        .i_action          (i_action),
        .i_level           (i_level),
        .i_now_us          (i_now_us),
        .i_system_state    (i_system_state),
        .i_failsafe_state  (i_failsafe_state),
        .i_rate_result     (i_rate_result),
        .i_control_result  (i_control_result),
        .i_mixer_valid     (i_mixer_valid),
        .i_mixer_saturated (i_mixer_saturated),
        .i_release_count   (i_release_count),
        .o_q_valid         (w_q_valid),
        .o_q_item          (w_q_item),
        .i_q_pop           (w_q_pop)
    );

    trc_back #(
        .RING_SLOTS (RING_SLOTS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_valid         (w_q_valid),
        .i_q_item          (w_q_item),
        .o_q_pop           (w_q_pop),
        .o_valid           (o_out_valid),
        .i_stall           (i_out_stall),
        .o_accepted        (o_accepted),
        .o_slot_index      (o_slot_index),
        .o_record_sequence (o_record_sequence),
        .o_event_flags     (o_event_flags),
        .o_capture_number  (o_capture_number),
        .o_current_level   (o_current_level),
        .o_pending_records (o_pending_records),
        .o_dropped_records (o_dropped_records),
        .o_capturing       (o_capturing)
    );

endmodule

>>> verif/tb_trace_capture_trigger_ring.sv
// Self-checking bench for trace_capture_trigger_ring: random and directed
// transactions, a scoreboard class that predicts each result. Uses trc_pkg.
module tb_trace_capture_trigger_ring;

    localparam int SLOTS = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        trc_pkg::t_action action;
        logic [2:0]  level;
        logic [63:0] now_us;
        logic [7:0]  sys;
        logic [7:0]  fs;
        logic [7:0]  rr;
        logic [7:0]  cr;
        logic        mvalid;
        logic        msat;
        logic [6:0]  rel;
    } t_txn;

    typedef struct {
        logic        accepted;
        logic [5:0]  slot;
        logic [63:0] seq;
        logic [5:0]  flags;
        logic [31:0] capture;
        logic [2:0]  level;
        logic [6:0]  pending;
        logic [63:0] dropped;
        logic        capturing;
    } t_rec;

    class trace_scoreboard;
        logic [19:0] c_low, c_high, c_full;
        logic [7:0]  c_armed, c_fault, c_disarmed;
        logic [2:0]  lvl;
        logic [31:0] cap_id;
        logic [19:0] period;
        logic [63:0] due_at;
        bit          seen;
        logic [7:0]  l_sys, l_fs, l_rr, l_cr;
        bit          l_sat, armed;
        logic [63:0] written, released, drops;
        t_rec        expected_q[$];
        int          errors;

        function void clear_capture();
            seen = 0; l_sys = 0; l_fs = 0; l_rr = 0; l_cr = 0;
            l_sat = 0; armed = 0; written = 0; released = 0; drops = 0;
        endfunction

        function void reset_all();
            c_low = trc_pkg::RST_LOW; c_high = trc_pkg::RST_HIGH;
            c_full = trc_pkg::RST_FULL; c_armed = trc_pkg::RST_ARMED;
            c_fault = trc_pkg::RST_FAULT; c_disarmed = trc_pkg::RST_DISARMED;
            lvl = 0; cap_id = 0; period = 0; due_at = 0;
            clear_capture();
            expected_q.delete();
            errors = 0;
        endfunction

        function void write_reg(trc_pkg::t_cfg_idx idx, logic [19:0] v);
            case (idx)
                trc_pkg::CFG_LOW:      c_low = v;
                trc_pkg::CFG_HIGH:     c_high = v;
                trc_pkg::CFG_FULL:     c_full = v;
                trc_pkg::CFG_ARMED:    c_armed = v[7:0];
                trc_pkg::CFG_FAULT:    c_fault = v[7:0];
                trc_pkg::CFG_DISARMED: c_disarmed = v[7:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] pending_count();
            return (written < released) ? 64'd0 : written - released;
        endfunction

        function bit due_now(logic [63:0] now);
            logic [63:0] base;
            if (period == 0 || now < due_at) return 0;
            base = due_at + ((now - due_at) / period) * period;
            if (64'hFFFF_FFFF_FFFF_FFFF - base < period)
                due_at = 64'hFFFF_FFFF_FFFF_FFFF;
            else
                due_at = base + period;
            return 1;
        endfunction

        function void note_input(t_txn t);
            t_rec r;
            bit sat, periodic, stop_now;
            logic [63:0] p;
            r = '{default: 0};
            case (t.action)
                trc_pkg::ACT_START: begin
                    if (lvl == 0 && t.level >= trc_pkg::LVL_EVENTS
                        && t.level <= trc_pkg::LVL_FULL) begin
                        if (cap_id != 32'hFFFF_FFFF) cap_id++;
                        lvl = t.level;
                        period = (t.level == trc_pkg::LVL_LOW) ? c_low :
                                 (t.level == trc_pkg::LVL_HIGH) ? c_high :
                                 (t.level == trc_pkg::LVL_FULL) ? c_full : 20'd0;
                        due_at = t.now_us;
                        clear_capture();
                        r.accepted = 1;
                    end
                end
                trc_pkg::ACT_STOP: begin
                    lvl = 0; period = 0; r.accepted = 1;
                end
                trc_pkg::ACT_RELEASE: begin
                    if (t.rel <= pending_count()) begin
                        released += t.rel; r.accepted = 1;
                    end
                end
                default: begin
                    if (lvl != 0) begin
                        sat = t.mvalid && t.msat;
                        if (!seen) r.flags[trc_pkg::EV_STARTED] = 1;
                        else begin
                            r.flags[trc_pkg::EV_STATE] = t.sys != l_sys;
                            r.flags[trc_pkg::EV_FAILSAFE] = t.fs != l_fs;
                            r.flags[trc_pkg::EV_RATE] = t.rr != l_rr;
                            r.flags[trc_pkg::EV_CONTROL] = t.cr != l_cr;
                            r.flags[trc_pkg::EV_SAT] = sat && !l_sat;
                        end
                        l_sys = t.sys; l_fs = t.fs; l_rr = t.rr; l_cr = t.cr;
                        l_sat = sat; seen = 1;
                        if (t.sys == c_armed) armed = 1;
                        periodic = due_now(t.now_us);
                        stop_now = (t.sys == c_fault) || (armed && t.sys == c_disarmed);
                        if (periodic || r.flags != 0 || stop_now) begin
                            if (written - released >= SLOTS) begin
                                if (drops != 64'hFFFF_FFFF_FFFF_FFFF) drops++;
                            end else begin
                                r.slot = 6'(written % SLOTS);
                                r.seq = written + 1;
                                written++;
                                r.accepted = 1;
                            end
                            if (stop_now) begin
                                lvl = 0; period = 0;
                            end
                        end
                    end
                end
            endcase
            p = pending_count();
            r.pending = (p > 127) ? 7'd127 : p[6:0];
            r.capture = cap_id;
            r.level = lvl;
            r.dropped = drops;
            r.capturing = lvl != 0;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_rec a);
            t_rec e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transaction");
                return;
            end
            e = expected_q.pop_front();
            if (a !== e) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp acc=%0d slot=%0d seq=%0d ev=%h id=%0d lvl=%0d pend=%0d drop=%0d cap=%0d | got acc=%0d slot=%0d seq=%0d ev=%h id=%0d lvl=%0d pend=%0d drop=%0d cap=%0d",
                        e.accepted, e.slot, e.seq, e.flags, e.capture, e.level, e.pending,
                        e.dropped, e.capturing, a.accepted, a.slot, a.seq, a.flags, a.capture,
                        a.level, a.pending, a.dropped, a.capturing);
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    logic [1:0]  action;
    logic [2:0]  level;
    logic [63:0] now_us;
    logic [7:0]  sys, fs, rr, cr;
    logic        mvalid, msat;
    logic [6:0]  rel;
    logic        o_acc, o_cap;
    logic [5:0]  o_slot, o_ev;
    logic [63:0] o_seq, o_drop;
    logic [31:0] o_id;
    logic [2:0]  o_lvl;
    logic [6:0]  o_pend;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [19:0] cfg_wdata;

    trace_capture_trigger_ring dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_action(action), .i_level(level), .i_now_us(now_us),
        .i_system_state(sys), .i_failsafe_state(fs), .i_rate_result(rr),
        .i_control_result(cr), .i_mixer_valid(mvalid), .i_mixer_saturated(msat),
        .i_release_count(rel),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_accepted(o_acc), .o_slot_index(o_slot), .o_record_sequence(o_seq),
        .o_event_flags(o_ev), .o_capture_number(o_id), .o_current_level(o_lvl),
        .o_pending_records(o_pend), .o_dropped_records(o_drop), .o_capturing(o_cap),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_wdata(cfg_wdata)
    );

    trace_scoreboard sb;
    int  send_idle_pct, recv_idle_pct;
    int  quiet_cycles;
    bit  timed_out;
    logic [63:0] clock_us;
    t_txn txn_q[$];

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (out_valid && !out_stall)
                sb.check_result('{o_acc, o_slot, o_seq, o_ev, o_id, o_lvl, o_pend,
                                  o_drop, o_cap});
        end
    end

    always @(posedge clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (rst_n) out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic send_txn(t_txn t);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        action <= t.action; level <= t.level; now_us <= t.now_us;
        sys <= t.sys; fs <= t.fs; rr <= t.rr; cr <= t.cr;
        mvalid <= t.mvalid; msat <= t.msat; rel <= t.rel;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(t);
        @(negedge clk);
    endtask

    task automatic write_reg(trc_pkg::t_cfg_idx idx, logic [19:0] v);
        cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= v;
        @(negedge clk);
        sb.write_reg(idx, v);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    function automatic t_txn mk(trc_pkg::t_action a, logic [2:0] l, logic [63:0] n,
                                logic [7:0] s, logic [6:0] r);
        t_txn t;
        t.action = a; t.level = l; t.now_us = n; t.sys = s;
        t.fs = 8'($urandom_range(3)); t.rr = 8'($urandom_range(3));
        t.cr = 8'($urandom_range(3));
        t.mvalid = 1'($urandom); t.msat = 1'($urandom); t.rel = r;
        return t;
    endfunction

    // Mostly a well-formed capture: start, a run of samples with advancing time,
    // occasional releases; faults and noise now and then.
    function automatic t_txn rand_txn();
        t_txn t;
        int k;
        k = $urandom_range(99);
        clock_us += 64'($urandom_range(3000));
        if (k < 8)
            t = mk(trc_pkg::ACT_START,
                   (k < 6) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(7)),
                   clock_us, 8'd0, 7'd0);
        else if (k < 10)
            t = mk(trc_pkg::ACT_STOP, 3'($urandom), clock_us, 8'd0, 7'd0);
        else if (k < 24)
            t = mk(trc_pkg::ACT_RELEASE, 3'd0, clock_us, 8'd0,
                   ($urandom_range(9) == 0) ? 7'($urandom_range(127)) :
                   7'($urandom_range(32'(sb.pending_count() > 64 ? 64
                                                : sb.pending_count()))));
        else begin
            t = mk(trc_pkg::ACT_SAMPLE, 3'($urandom), clock_us,
                   ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(4)), 7'd0);
            if ($urandom_range(49) == 0) t.now_us = {$urandom, $urandom};
            if ($urandom_range(3) == 0) begin
                t.fs = 8'($urandom); t.rr = 8'($urandom); t.cr = 8'($urandom);
            end
        end
        return t;
    endfunction

    initial begin
        t_txn t;
        sb = new();
        sb.reset_all();
        timed_out = 0; quiet_cycles = 0; clock_us = 0;
        rst_n = 0; in_valid = 0; out_stall = 0; cfg_we = 0; cfg_idx = trc_pkg::CFG_LOW;
        cfg_wdata = 0; action = trc_pkg::ACT_SAMPLE; level = 0; now_us = 0;
        sys = 0; fs = 0; rr = 0; cr = 0; mvalid = 0; msat = 0; rel = 0;
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;

        // directed: refused starts, start, samples, releases, disarm and fault stops
        txn_q.push_back(mk(trc_pkg::ACT_SAMPLE, 0, 5, 2, 0));
        txn_q.push_back(mk(trc_pkg::ACT_START, 0, 0, 0, 0));
        txn_q.push_back(mk(trc_pkg::ACT_START, 7, 0, 0, 0));
        txn_q.push_back(mk(trc_pkg::ACT_RELEASE, 0, 0, 0, 1));
        txn_q.push_back(mk(trc_pkg::ACT_START, trc_pkg::LVL_FULL, 100, 0, 0));
        txn_q.push_back(mk(trc_pkg::ACT_START, trc_pkg::LVL_LOW, 100, 0, 0));
        for (int i = 0; i < 8; i++)
            txn_q.push_back(mk(trc_pkg::ACT_SAMPLE, 0, 64'(100 + i * 700), 0, 0));
        txn_q.push_back(mk(trc_pkg::ACT_SAMPLE, 0, 64'hFFFF_FFFF_FFFF_FF00, 2, 0));
        txn_q.push_back(mk(trc_pkg::ACT_SAMPLE, 0, 64'hFFFF_FFFF_FFFF_FFFF, 2, 0));
        txn_q.push_back(mk(trc_pkg::ACT_RELEASE, 0, 0, 0, 127));
        txn_q.push_back(mk(trc_pkg::ACT_RELEASE, 0, 0, 0, 3));
        txn_q.push_back(mk(trc_pkg::ACT_SAMPLE, 0, 0, 1, 0));
        txn_q.push_back(mk(trc_pkg::ACT_STOP, 0, 0, 0, 0));
        txn_q.push_back(mk(trc_pkg::ACT_START, trc_pkg::LVL_EVENTS, 0, 0, 0));
        txn_q.push_back(mk(trc_pkg::ACT_SAMPLE, 0, 0, 3, 0));
        foreach (txn_q[i]) send_txn(txn_q[i]);
        drain();

        // three phases, each with its own idle rates and register setting
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 69 : 0;
            recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 29 : 0;
            write_reg(trc_pkg::CFG_LOW,
                      (ph == 0) ? 20'd1 : (ph == 1) ? 20'd1000000 : 20'd0);
            write_reg(trc_pkg::CFG_HIGH,
                      (ph == 2) ? 20'hFFFFF : 20'($urandom_range(1, 5000)));
            write_reg(trc_pkg::CFG_FULL, 20'($urandom_range(1, 2000)));
            write_reg(trc_pkg::CFG_ARMED, (ph == 2) ? 20'd255 : 20'd2);
            write_reg(trc_pkg::CFG_FAULT, (ph == 1) ? 20'd0 : 20'd3);
            write_reg(trc_pkg::CFG_DISARMED, 20'($urandom_range(1, 4)));
            cfg_we <= 0;
            for (int i = 0; i < 510; i++) send_txn(rand_txn());
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
